### rtl/core/rsso_pkg.sv
// Shared types, constants and the half-angle sine table for the range scan
// smallest-object block. No dependencies.
package rsso_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int DEF_MAX_SAMPLES  = 128;
  localparam int DEF_OBJ_CAPACITY = 16;
  localparam int DEF_ANGLE_STEP   = 2;

  // Depth of the command queue between segmenter and evaluator (power of two)
  localparam int QUEUE_DEPTH = 4;

  // Register reset values
  localparam logic [7:0] NEAR_LIMIT_RST      = 8'd50;
  localparam logic [7:0] MATCH_TOLERANCE_RST = 8'd3;

  // Value reported when no object qualifies
  localparam logic [7:0] NONE_VALUE = 8'd255;

  // Register indexes on the configuration port
  localparam logic [7:0] REG_NEAR_LIMIT      = 8'd0;
  localparam logic [7:0] REG_MATCH_TOLERANCE = 8'd1;

  // Largest delta that the sine table covers, and the fold point
  localparam int SINE_LAST = 180;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Fields wide enough for the largest legal parameter values
  typedef logic [7:0] son_addr_t;  // MAX_SAMPLES up to 256
  typedef logic [5:0] obj_addr_t;  // object capacity up to 64
  typedef logic [6:0] obj_cnt_t;   // object count up to 64

  typedef struct packed {
    logic [7:0] sweep_angle;
    logic [7:0] ir_range;
    logic [7:0] sonar_range;
    logic       last_sample;
  } in_t;

  typedef struct packed {
    logic [7:0] target_angle;
    logic [7:0] target_width;
    logic       found;
  } out_t;

  typedef struct packed {
    logic [7:0] near_limit;
    logic [7:0] match_tolerance;
  } cfg_t;

  // One queue entry: the store updates caused by one sample, plus an
  // optional request to evaluate the finished sweep
  typedef struct packed {
    logic       son_we;
    son_addr_t  son_addr;
    logic [7:0] son_data;
    logic       obj_we;
    logic       obj_is_end;
    obj_addr_t  obj_addr;
    logic [7:0] obj_angle;
    logic       eval;
    obj_cnt_t   eval_count;
  } cmd_t;

  typedef enum logic [2:0] {
    EV_IDLE,
    EV_OBJ,
    EV_IDX,
    EV_READ,
    EV_MUL,
    EV_CMP,
    EV_EMIT
  } ev_state_t;

  typedef logic [SINE_LAST:0][16:0] sine_lut_t;

  // Q16 sin(delta/2 degrees): Q30 Taylor series, rounded half up to Q16
  function automatic logic [16:0] half_sine_q16(input int unsigned delta);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x    = (64'(delta) * PI_Q30) / 64'd360;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + 64'd8192) >> 14;
    if (r > 64'd65536) begin
      r = 64'd65536;
    end
    return r[16:0];
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int d = 0; d <= SINE_LAST; d++) begin
      lut[d] = half_sine_q16(d);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

### rtl/core/rsso_front.sv
// Segmenter: takes sample beats, tracks the open object and emits one queue
// command per sample. Depends on rsso_pkg.
module rsso_front #(
  parameter int MAX_SAMPLES  = rsso_pkg::DEF_MAX_SAMPLES,
  parameter int OBJ_CAPACITY = rsso_pkg::DEF_OBJ_CAPACITY
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  rsso_pkg::in_t  item,
  input  rsso_pkg::cfg_t cfg,
  output rsso_pkg::cmd_t cmd
);

  localparam int SIW = $clog2(MAX_SAMPLES + 1);
  localparam int OCW = $clog2(OBJ_CAPACITY + 1);

  logic [SIW-1:0] sample_idx_r, sample_idx_nxt;
  logic [7:0]     prev_ir_r, prev_ir_nxt;
  logic [7:0]     prev_angle_r, prev_angle_nxt;
  logic           open_r, open_nxt;
  logic [OCW-1:0] count_r, count_nxt;

  logic       have_prev;
  logic [7:0] diff;
  logic       cur_near;
  logic       start_hit;
  logic       do_start;
  logic       do_end;
  logic       son_ok;

  // Classify the pair (previous sample, this sample)
  always_comb begin
    have_prev = (sample_idx_r != '0);
    diff      = (prev_ir_r >= item.ir_range) ? (prev_ir_r - item.ir_range)
                                             : (item.ir_range - prev_ir_r);
    cur_near  = (prev_ir_r < cfg.near_limit);
    start_hit = have_prev && !open_r && cur_near && (diff < cfg.match_tolerance);
    do_start  = start_hit && (count_r < OCW'(OBJ_CAPACITY));
    do_end    = have_prev && !start_hit && open_r && cur_near &&
                (item.ir_range >= cfg.near_limit);
    son_ok    = (sample_idx_r < SIW'(MAX_SAMPLES));
  end

  // Build the command for this beat
  always_comb begin
    cmd.son_we     = son_ok;
    cmd.son_addr   = rsso_pkg::son_addr_t'(sample_idx_r);
    cmd.son_data   = item.sonar_range;
    cmd.obj_we     = do_start || do_end;
    cmd.obj_is_end = do_end;
    cmd.obj_addr   = rsso_pkg::obj_addr_t'(count_r);
    cmd.obj_angle  = prev_angle_r;
    cmd.eval       = item.last_sample;
    cmd.eval_count = do_end ? rsso_pkg::obj_cnt_t'(count_r + 1'b1)
                            : rsso_pkg::obj_cnt_t'(count_r);
  end

  // Advance sweep state; clear it after the last sample
  always_comb begin
    sample_idx_nxt = sample_idx_r;
    prev_ir_nxt    = prev_ir_r;
    prev_angle_nxt = prev_angle_r;
    open_nxt       = open_r;
    count_nxt      = count_r;
    if (accept) begin
      if (item.last_sample) begin
        sample_idx_nxt = '0;
        prev_ir_nxt    = '0;
        prev_angle_nxt = '0;
        open_nxt       = 1'b0;
        count_nxt      = '0;
      end else begin
        if (son_ok) begin
          sample_idx_nxt = sample_idx_r + 1'b1;
        end
        prev_ir_nxt    = item.ir_range;
        prev_angle_nxt = item.sweep_angle;
        if (do_start) begin
          open_nxt = 1'b1;
        end else if (do_end) begin
          open_nxt  = 1'b0;
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_idx_r <= '0;
      prev_ir_r    <= '0;
      prev_angle_r <= '0;
      open_r       <= 1'b0;
      count_r      <= '0;
    end else begin
      sample_idx_r <= sample_idx_nxt;
      prev_ir_r    <= prev_ir_nxt;
      prev_angle_r <= prev_angle_nxt;
      open_r       <= open_nxt;
      count_r      <= count_nxt;
    end
  end

endmodule

### rtl/core/rsso_queue.sv
// Short command FIFO between segmenter and evaluator.
// Depends on rsso_pkg for the command type.
module rsso_queue #(
  parameter int DEPTH = rsso_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rsso_pkg::cmd_t push_data,
  input  logic           pop,
  output rsso_pkg::cmd_t pop_data,
  output logic           full,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rsso_pkg::cmd_t entries_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;

  assign full     = (fill_r == CW'(DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = entries_r[rd_ptr_r];

  // Wrap pointers and track fill
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/rsso_back.sv
// Evaluator: applies queued store writes and, on a sweep's end, measures each
// closed object and reports the narrowest. Depends on rsso_pkg.
module rsso_back #(
  parameter int MAX_SAMPLES  = rsso_pkg::DEF_MAX_SAMPLES,
  parameter int OBJ_CAPACITY = rsso_pkg::DEF_OBJ_CAPACITY,
  parameter int ANGLE_STEP   = rsso_pkg::DEF_ANGLE_STEP
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  rsso_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  output rsso_pkg::out_t out_data
);

  localparam int SAW = $clog2(MAX_SAMPLES);
  localparam int OAW = (OBJ_CAPACITY > 1) ? $clog2(OBJ_CAPACITY) : 1;
  localparam int OCW = $clog2(OBJ_CAPACITY + 1);
  // sum / (2*ANGLE_STEP) as a multiply by a rounded-up reciprocal
  localparam int IDX_DIV  = 2 * ANGLE_STEP;
  localparam int IDX_SH   = 18;
  localparam int IDX_RCP  = ((1 << IDX_SH) + IDX_DIV - 1) / IDX_DIV;

  // Stores
  logic [7:0] sonar_mem [MAX_SAMPLES];
  logic [7:0] start_mem [OBJ_CAPACITY];
  logic [7:0] end_mem   [OBJ_CAPACITY];

  rsso_pkg::ev_state_t state_r, state_nxt;
  logic [OCW-1:0] obj_cnt_r, obj_cnt_nxt;
  logic [OAW-1:0] obj_i_r, obj_i_nxt;
  logic [7:0]     best_w_r, best_w_nxt;
  logic [7:0]     best_a_r, best_a_nxt;
  logic           found_r, found_nxt;

  // Per-object datapath registers
  logic [7:0]  a0_r, a1_r;
  logic [7:0]  delta_r;
  logic [7:0]  mid_r;
  logic [8:0]  idx_r;
  logic        idx_ok_r;
  logic [7:0]  son_q_r;
  logic [16:0] sin_r;
  logic [7:0]  w_r;

  logic [8:0]  ang_sum;
  logic [8:0]  ang_abs;
  logic [8:0]  ang_fold;
  logic [27:0] idx_prod;
  logic [7:0]  sonar_d;
  logic [24:0] w_prod;
  logic [9:0]  w_full;

  // Apply queued writes as they are popped
  always_ff @(posedge clk) begin
    if (q_pop && q_data.son_we) begin
      sonar_mem[q_data.son_addr[SAW-1:0]] <= q_data.son_data;
    end
    if (q_pop && q_data.obj_we && !q_data.obj_is_end) begin
      start_mem[q_data.obj_addr[OAW-1:0]] <= q_data.obj_angle;
    end
    if (q_pop && q_data.obj_we && q_data.obj_is_end) begin
      end_mem[q_data.obj_addr[OAW-1:0]] <= q_data.obj_angle;
    end
  end

  // Fetch object angles
  always_ff @(posedge clk) begin
    if (state_r == rsso_pkg::EV_OBJ) begin
      a0_r <= start_mem[obj_i_r];
      a1_r <= end_mem[obj_i_r];
    end
  end

  // Form sonar index, folded delta and midpoint
  always_comb begin
    ang_sum  = {1'b0, a0_r} + {1'b0, a1_r};
    ang_abs  = (a1_r >= a0_r) ? {1'b0, a1_r - a0_r} : {1'b0, a0_r - a1_r};
    ang_fold = (ang_abs > 9'(rsso_pkg::SINE_LAST)) ? (9'd360 - ang_abs) : ang_abs;
    idx_prod = 28'(ang_sum) * 28'(IDX_RCP);
  end

  always_ff @(posedge clk) begin
    if (state_r == rsso_pkg::EV_IDX) begin
      delta_r  <= ang_fold[7:0];
      mid_r    <= ang_sum[8:1];
      idx_r    <= idx_prod[IDX_SH+8:IDX_SH];
      idx_ok_r <= (idx_prod[IDX_SH+8:IDX_SH] < 9'(MAX_SAMPLES));
    end
  end

  // Read sonar range and sine
  always_ff @(posedge clk) begin
    if (state_r == rsso_pkg::EV_READ) begin
      son_q_r <= sonar_mem[idx_r[SAW-1:0]];
      sin_r   <= rsso_pkg::SINE_LUT[delta_r];
    end
  end

  // Width = floor(2*d*S/65536), saturated
  always_comb begin
    sonar_d = idx_ok_r ? son_q_r : 8'd0;
    w_prod  = 25'(sonar_d) * 25'(sin_r);
    w_full  = w_prod[24:15];
  end

  always_ff @(posedge clk) begin
    if (state_r == rsso_pkg::EV_MUL) begin
      w_r <= (w_full > 10'd255) ? 8'd255 : w_full[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rsso_pkg::EV_IDLE;
      obj_cnt_r <= '0;
      obj_i_r   <= '0;
      best_w_r  <= rsso_pkg::NONE_VALUE;
      best_a_r  <= rsso_pkg::NONE_VALUE;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      obj_cnt_r <= obj_cnt_nxt;
      obj_i_r   <= obj_i_nxt;
      best_w_r  <= best_w_nxt;
      best_a_r  <= best_a_nxt;
      found_r   <= found_nxt;
    end
  end

  // Sequence the evaluation, one object at a time
  always_comb begin
    state_nxt   = state_r;
    obj_cnt_nxt = obj_cnt_r;
    obj_i_nxt   = obj_i_r;
    best_w_nxt  = best_w_r;
    best_a_nxt  = best_a_r;
    found_nxt   = found_r;
    q_pop       = 1'b0;
    out_valid   = 1'b0;
    unique case (state_r)
      rsso_pkg::EV_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.eval) begin
            obj_cnt_nxt = OCW'(q_data.eval_count);
            obj_i_nxt   = '0;
            state_nxt   = (q_data.eval_count == '0) ? rsso_pkg::EV_EMIT
                                                    : rsso_pkg::EV_OBJ;
          end
        end
      end
      rsso_pkg::EV_OBJ:  state_nxt = rsso_pkg::EV_IDX;
      rsso_pkg::EV_IDX:  state_nxt = rsso_pkg::EV_READ;
      rsso_pkg::EV_READ: state_nxt = rsso_pkg::EV_MUL;
      rsso_pkg::EV_MUL:  state_nxt = rsso_pkg::EV_CMP;
      rsso_pkg::EV_CMP: begin
        if (w_r < best_w_r) begin
          best_w_nxt = w_r;
          best_a_nxt = mid_r;
          found_nxt  = 1'b1;
        end
        if (OCW'(obj_i_r) == obj_cnt_r - 1'b1) begin
          state_nxt = rsso_pkg::EV_EMIT;
        end else begin
          obj_i_nxt = obj_i_r + 1'b1;
          state_nxt = rsso_pkg::EV_OBJ;
        end
      end
      rsso_pkg::EV_EMIT: begin
        out_valid  = 1'b1;
        best_w_nxt = rsso_pkg::NONE_VALUE;
        best_a_nxt = rsso_pkg::NONE_VALUE;
        found_nxt  = 1'b0;
        state_nxt  = rsso_pkg::EV_IDLE;
      end
      default: state_nxt = rsso_pkg::EV_IDLE;
    endcase
  end

  assign out_data.target_angle = best_a_r;
  assign out_data.target_width = best_w_r;
  assign out_data.found        = found_r;

endmodule

### rtl/core/range_scan_smallest_object.sv
// Top level of the range scan smallest-object block: configuration registers,
// segmenter, command queue and evaluator. Depends on rsso_pkg and its modules.
//
// Samples of a sweep are taken one per clock while busy is low. The sample
// marked last_sample closes the sweep; the evaluator then measures each closed
// object in turn, over one shared index/sine/multiply path, before the result
// strobe. The command queue (four entries) keeps taking samples of the next
// sweep during that time; busy rises once it is full.
// The result sits on out_data for exactly the one cycle that out_valid is
// high, and the receiver cannot hold it off. No clearing pass after reset.
module range_scan_smallest_object #(
  parameter int MAX_SAMPLES  = rsso_pkg::DEF_MAX_SAMPLES,
  parameter int OBJ_CAPACITY = rsso_pkg::DEF_OBJ_CAPACITY,
  parameter int ANGLE_STEP   = rsso_pkg::DEF_ANGLE_STEP
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rsso_pkg::in_t  in_data,
  output logic           out_valid,
  output rsso_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_index,
  input  logic [7:0]     cfg_data
);

  rsso_pkg::cfg_t cfg_r, cfg_nxt;
  rsso_pkg::cmd_t cmd;
  rsso_pkg::cmd_t q_data;
  logic           accept;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  assign busy      = q_full;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rsso_pkg::REG_NEAR_LIMIT:      cfg_nxt.near_limit      = cfg_data;
        rsso_pkg::REG_MATCH_TOLERANCE: cfg_nxt.match_tolerance = cfg_data;
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_limit      <= rsso_pkg::NEAR_LIMIT_RST;
      cfg_r.match_tolerance <= rsso_pkg::MATCH_TOLERANCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rsso_front #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .OBJ_CAPACITY (OBJ_CAPACITY)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .cfg    (cfg_r),
    .cmd    (cmd)
  );

  rsso_queue #(
    .DEPTH (rsso_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (cmd),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  rsso_back #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .OBJ_CAPACITY (OBJ_CAPACITY),
    .ANGLE_STEP   (ANGLE_STEP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### tb/range_scan_smallest_object_tb.sv
// Self-checking testbench for range_scan_smallest_object: directed sweeps, then
// random sweeps under several register settings, checked against a predictor.
// Depends on rsso_pkg and the range_scan_smallest_object RTL.
module range_scan_smallest_object_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SONAR_DEPTH   = rsso_pkg::DEF_MAX_SAMPLES;
  localparam int OBJ_SLOTS     = rsso_pkg::DEF_OBJ_CAPACITY;
  localparam int STEP          = rsso_pkg::DEF_ANGLE_STEP;
  localparam int TARGET_ITEMS  = 1750;
  localparam int CALM_ITEMS    = 200;
  localparam int PHASE_ITEMS   = 250;
  localparam int SETTLE_CYCLES = 5 * rsso_pkg::DEF_OBJ_CAPACITY + 2 +
                                 4 * rsso_pkg::QUEUE_DEPTH + 40;
  localparam int MAX_PRINTS    = 40;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam int DIRECTED_ROWS = 17;
  localparam logic [63:0] PI_FIXED_Q30 = 64'd3373259426;

  localparam rsso_pkg::out_t UNTYPED    = '0;
  localparam rsso_pkg::out_t NONE_FOUND = '{rsso_pkg::NONE_VALUE, rsso_pkg::NONE_VALUE,
                                            1'b0};

  typedef struct packed {
    rsso_pkg::in_t  stim;
    logic           typed;
    rsso_pkg::out_t want;
  } plan_row_t;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  rsso_pkg::in_t  in_data;
  logic           out_valid;
  rsso_pkg::out_t out_data;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [7:0]     cfg_index;
  logic [7:0]     cfg_data;

  range_scan_smallest_object DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: registers, sonar store, object table and sweep progress
  logic [7:0]  near_lim  = rsso_pkg::NEAR_LIMIT_RST;
  logic [7:0]  match_tol = rsso_pkg::MATCH_TOLERANCE_RST;
  logic [7:0]  sonar_mem [SONAR_DEPTH];
  logic [7:0]  obj_start [OBJ_SLOTS];
  logic [7:0]  obj_end   [OBJ_SLOTS];
  int unsigned scan_idx   = 0;
  logic [7:0]  prev_ir    = '0;
  logic [7:0]  prev_angle = '0;
  bit          obj_open   = 0;
  int unsigned obj_cnt    = 0;
  logic [16:0] sine_q16 [0:rsso_pkg::SINE_LAST];

  rsso_pkg::out_t pending_targets [$];
  rsso_pkg::out_t oldest_target;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  bit          idle_on = 1;
  bit          calm = 0;
  plan_row_t   plan_rows [DIRECTED_ROWS];
  logic [7:0]  near_plan [5] = '{8'd0, 8'd255, 8'd200, 8'd90, 8'd1};
  logic [7:0]  tol_plan  [5] = '{8'd5, 8'd255, 8'd0, 8'd12, 8'd1};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #TIMEOUT_NS;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Q16 sine of half the angle: Q30 series in nine terms, rounded half up
  function automatic logic [16:0] sin_half_q16(input int unsigned deg);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] part;
    logic [63:0] acc;
    ang    = (64'(deg) * PI_FIXED_Q30) / 64'd360;
    ang_sq = (ang * ang) >> 30;
    part   = ang;
    acc    = ang;
    for (int k = 1; k <= 8; k++) begin
      part = ((part * ang_sq) >> 30) / 64'(2 * k * (2 * k + 1));
      acc  = (k % 2 == 1) ? acc - part : acc + part;
    end
    acc = (acc + 64'd8192) >> 14;
    return (acc > 64'd65536) ? 17'd65536 : acc[16:0];
  endfunction

  function automatic logic [7:0] span_width(input logic [7:0] range_cm,
                                            input logic [7:0] a0,
                                            input logic [7:0] a1);
    int          delta;
    logic [63:0] w;
    delta = int'(a1) - int'(a0);
    if (delta < 0) delta = -delta;
    if (delta > rsso_pkg::SINE_LAST) delta = 360 - delta;
    w = (64'd2 * 64'(range_cm) * 64'(sine_q16[delta])) >> 16;
    return (w > 64'd255) ? 8'd255 : w[7:0];
  endfunction

  // Advance the predictor by one sample; on the last one compute the target
  task automatic scan_sample(input rsso_pkg::in_t s, output bit emit,
                             output rsso_pkg::out_t res);
    int          diff;
    int unsigned slot;
    int          mid;
    logic [7:0]  range_cm;
    logic [7:0]  w;
    logic [7:0]  best_w;
    logic [7:0]  best_a;
    bit          hit;
    emit = 0;
    res  = '0;
    // segment on the pair (previous sample, this sample)
    if (scan_idx > 0) begin
      diff = int'(prev_ir) - int'(s.ir_range);
      if (diff < 0) diff = -diff;
      if (!obj_open && prev_ir < near_lim && diff < int'(match_tol)) begin
        if (obj_cnt < OBJ_SLOTS) begin
          obj_start[obj_cnt] = prev_angle;
          obj_open = 1;
        end
      end else if (obj_open && prev_ir < near_lim && s.ir_range >= near_lim) begin
        obj_end[obj_cnt] = prev_angle;
        obj_open = 0;
        obj_cnt++;
      end
    end
    if (scan_idx < SONAR_DEPTH) begin
      sonar_mem[scan_idx] = s.sonar_range;
      scan_idx++;
    end
    prev_ir    = s.ir_range;
    prev_angle = s.sweep_angle;
    if (s.last_sample) begin
      best_w = rsso_pkg::NONE_VALUE;
      best_a = rsso_pkg::NONE_VALUE;
      hit    = 0;
      // keep only a strictly narrower object
      for (int i = 0; i < obj_cnt; i++) begin
        slot     = (int'(obj_start[i]) + int'(obj_end[i])) / (2 * STEP);
        range_cm = (slot < SONAR_DEPTH) ? sonar_mem[slot] : 8'd0;
        w        = span_width(range_cm, obj_start[i], obj_end[i]);
        if (w < best_w) begin
          mid    = (int'(obj_start[i]) + int'(obj_end[i])) / 2;
          best_w = w;
          best_a = mid[7:0];
          hit    = 1;
        end
      end
      res      = '{best_a, best_w, hit};
      emit     = 1;
      scan_idx = 0;
      prev_ir  = '0;
      prev_angle = '0;
      obj_open = 0;
      obj_cnt  = 0;
    end
  endtask

  // Offer one sample beat, with an optional idle burst first
  task automatic send_item(input rsso_pkg::in_t s, input bit typed,
                           input rsso_pkg::out_t want);
    int unsigned    gap;
    bit             emit;
    rsso_pkg::out_t got;
    gap = 0;
    if (idle_on && !calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    scan_sample(s, emit, got);
    if (emit) pending_targets.push_back(typed ? want : got);
    items_sent++;
    calm = (items_sent >= TARGET_ITEMS - CALM_ITEMS);
  endtask

  // Hold off the sender until every expected target has come out
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_targets.size() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] near, input logic [7:0] tol);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= rsso_pkg::REG_NEAR_LIMIT;
    cfg_data  <= near;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    near_lim = near;
    cfg_index <= rsso_pkg::REG_MATCH_TOLERANCE;
    cfg_data  <= tol;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    match_tol = tol;
    cfg_valid <= 1'b0;
  endtask

  // Build one sweep of far and near runs; near runs mostly stay within tolerance
  task automatic run_sweep(input int unsigned len, input bit crowded);
    rsso_pkg::in_t s;
    logic [7:0]    angle;
    logic [7:0]    near_v;
    int unsigned   step;
    int unsigned   run_left;
    int unsigned   jit;
    int            level;
    bit            in_run;
    bit            wild_angle;
    bit            descend;
    angle      = 8'($urandom_range(0, 255));
    step       = $urandom_range(0, 4);
    descend    = ($urandom_range(0, 3) == 0);
    wild_angle = ($urandom_range(0, 7) == 0);
    in_run     = ($urandom_range(0, 1) == 1);
    run_left   = crowded ? $urandom_range(1, 2) : $urandom_range(1, 6);
    jit        = (match_tol > 0) ? match_tol - 1 : 0;
    near_v     = (near_lim > 0) ? 8'($urandom_range(0, near_lim - 1)) : 8'd0;
    idle_on    = ($urandom_range(0, 2) != 0);
    for (int k = 0; k < len; k++) begin
      if (run_left == 0) begin
        in_run   = !in_run;
        run_left = crowded ? $urandom_range(1, 2) : $urandom_range(1, 6);
        if (in_run && near_lim > 0) near_v = 8'($urandom_range(0, near_lim - 1));
      end
      run_left--;
      s = '0;
      s.sweep_angle = wild_angle ? 8'($urandom_range(0, 255)) : angle;
      angle = 8'(descend ? angle - step : angle + step);
      if (near_lim == 0 || $urandom_range(0, 9) == 0) begin
        s.ir_range = 8'($urandom_range(0, 255));
      end else if (in_run) begin
        level = int'(near_v) + int'($urandom_range(0, jit));
        if (level >= int'(near_lim)) level = int'(near_lim) - 1;
        s.ir_range = 8'(level);
      end else begin
        s.ir_range = 8'($urandom_range(near_lim, 255));
      end
      s.sonar_range = 8'($urandom_range(0, 255));
      s.last_sample = (k == len - 1);
      send_item(s, 1'b0, UNTYPED);
    end
  endtask

  // Compare each result beat with the oldest expected target
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_targets.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: %p", out_data));
      end else begin
        oldest_target = pending_targets.pop_front();
        if (out_data.target_angle !== oldest_target.target_angle)
          note_mismatch($sformatf("target_angle %0d, expected %0d",
                                  out_data.target_angle, oldest_target.target_angle));
        if (out_data.target_width !== oldest_target.target_width)
          note_mismatch($sformatf("target_width %0d, expected %0d",
                                  out_data.target_width, oldest_target.target_width));
        if (out_data.found !== oldest_target.found)
          note_mismatch($sformatf("found %0b, expected %0b",
                                  out_data.found, oldest_target.found));
      end
    end
  end

  initial begin
    logic [7:0]  next_near;
    logic [7:0]  next_tol;
    int unsigned len;
    int unsigned pick;
    int unsigned phase;
    int unsigned phase_items;
    bit          crowded;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int d = 0; d <= rsso_pkg::SINE_LAST; d++) sine_q16[d] = sin_half_q16(d);

    // angle, ir, sonar, last; typed target only where it is obvious
    plan_rows = '{
      // single sample right after reset: no pair, nothing found
      '{'{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, NONE_FOUND},
      // zero-width object at angle 2
      '{'{8'd2,   8'd10,  8'd7,   1'b0}, 1'b0, UNTYPED},
      '{'{8'd2,   8'd12,  8'd9,   1'b0}, 1'b0, UNTYPED},
      '{'{8'd3,   8'd255, 8'd255, 1'b0}, 1'b0, UNTYPED},
      '{'{8'd255, 8'd0,   8'd250, 1'b1}, 1'b1, '{8'd2, 8'd0, 1'b1}},
      // IR at the near limit, end before start, tolerance edge, open at end
      '{'{8'd8,   8'd49,  8'd200, 1'b0}, 1'b0, UNTYPED},
      '{'{8'd4,   8'd50,  8'd100, 1'b0}, 1'b0, UNTYPED},
      '{'{8'd6,   8'd49,  8'd60,  1'b0}, 1'b0, UNTYPED},
      '{'{8'd0,   8'd50,  8'd130, 1'b0}, 1'b0, UNTYPED},
      '{'{8'd0,   8'd20,  8'd0,   1'b0}, 1'b0, UNTYPED},
      '{'{8'd0,   8'd23,  8'd1,   1'b0}, 1'b0, UNTYPED},
      '{'{8'd4,   8'd21,  8'd77,  1'b0}, 1'b0, UNTYPED},
      '{'{8'd8,   8'd255, 8'd128, 1'b0}, 1'b0, UNTYPED},
      '{'{8'd10,  8'd30,  8'd64,  1'b0}, 1'b0, UNTYPED},
      '{'{8'd12,  8'd31,  8'd32,  1'b0}, 1'b0, UNTYPED},
      '{'{8'd180, 8'd30,  8'd16,  1'b1}, 1'b0, UNTYPED},
      // single-sample sweep after a full one
      '{'{8'd128, 8'd255, 8'd255, 1'b1}, 1'b1, NONE_FOUND}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan_rows[i]) send_item(plan_rows[i].stim, plan_rows[i].typed,
                                     plan_rows[i].want);

    // open with a sweep past the store size so every sonar entry is written
    phase = 0;
    phase_items = SONAR_DEPTH + 8;
    run_sweep(SONAR_DEPTH + 8, 1'b0);
    while (items_sent < TARGET_ITEMS) begin
      if (phase_items >= PHASE_ITEMS) begin
        if (phase < 5) begin
          next_near = near_plan[phase];
          next_tol  = tol_plan[phase];
        end else begin
          next_near = 8'($urandom_range(0, 255));
          next_tol  = 8'($urandom_range(0, 16));
        end
        apply_settings(next_near, next_tol);
        phase++;
        phase_items = 0;
      end
      crowded = 0;
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        len = 1;
      end else if (pick == 1) begin
        len = $urandom_range(SONAR_DEPTH + 1, SONAR_DEPTH + 30);
      end else if (pick <= 3) begin
        len = $urandom_range(40, 90);
        crowded = 1;
      end else begin
        len = $urandom_range(2, 40);
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
      run_sweep(len, crowded);
      phase_items += len;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
